// File: sv/rcd_pkg.sv
// rcd_pkg: types and constants for the chunk stream deframer
// used by rtmp_chunk_deframer and its checker; no dependencies
package rcd_pkg;

   typedef enum logic [2:0] {
      PH_BH0        = 3'd0,
      PH_BH_TWO     = 3'd1,
      PH_BH_THREE_A = 3'd2,
      PH_BH_THREE_B = 3'd3,
      PH_MSGHDR     = 3'd4,
      PH_EXT        = 3'd5,
      PH_PAYLOAD    = 3'd6,
      PH_ERROR      = 3'd7
   } phase_type;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_EMPTY   = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_FRESH      = 3'd1;
   localparam logic [2:0] ERR_MID_MSG    = 3'd2;
   localparam logic [2:0] ERR_LENGTH     = 3'd3;
   localparam logic [2:0] ERR_STREAM_ID  = 3'd4;

   localparam logic [23:0] EXT_MARK      = 24'hffffff;
   localparam logic [16:0] CID_CONTROL   = 17'd2;
   localparam logic [23:0] CHUNK_RESET   = 24'd128;

   // message header length per format
   function automatic logic [3:0] mh_len(input logic [1:0] fmt);
      logic [3:0] n;
      unique case (fmt)
         2'd0: n = 4'd11;
         2'd1: n = 4'd7;
         2'd2: n = 4'd3;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   // per stream table entry
   typedef struct packed {
      logic [30:0] timestamp;
      logic [23:0] delta;
      logic [23:0] length;
      logic [7:0]  mtype;
      logic [31:0] msg_id;
      logic        extended;
      logic        seen;
      logic        partial;
      logic [23:0] received;
   } entry_type;

endpackage

// File: sv/rtmp_chunk_deframer.sv
// rtmp_chunk_deframer: receive side chunk stream demultiplexer
// depends on rcd_pkg
//
// Takes one received byte per transfer and delivers at most one result per byte. Message
// header, extended timestamp and payload bytes go at one byte per cycle unless a waiting
// result is stalled. The per stream table lives in one memory with a registered read: the
// entry of the current stream is read when the basic header completes and is then held in a
// working register, which every later header and payload byte updates; it is written back on
// each update, so bytes of one chunk follow back to back. After the last basic header byte
// the input is stalled while the table is read, since the stream id is only known then. After
// reset the block sweeps all STREAM_SLOTS table entries to clear them before it takes the first
// byte. Results wait in an output register; while the receiver stalls a waiting result, no byte
// is taken. After any protocol error the block drops all bytes until reset.
module rtmp_chunk_deframer
   import rcd_pkg::*;
#(
   parameter int STREAM_SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [23:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [16:0] rsp_chunk_stream,
   output logic [7:0]  rsp_msg_type,
   output logic [23:0] rsp_msg_length,
   output logic [30:0] rsp_msg_timestamp,
   output logic [31:0] rsp_msg_stream_id,
   output logic        rsp_last,
   output logic [2:0]  rsp_error_code
);
   localparam int AW = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;

   // state
   logic [23:0] chunk_size_ff;
   phase_type   phase_ff, phase_in;
   logic [1:0]  fmt_ff, fmt_in;
   logic [16:0] cur_ff, cur_in;
   logic [3:0]  idx_ff, idx_in;
   logic [31:0] shift_ff, shift_in;
   logic [23:0] left_ff, left_in;
   logic        lookup_ff, lookup_in;   // table read in flight
   logic        clr_ff;
   logic [AW:0] clr_cnt_ff;
   entry_type   ent_ff, ent_in;
   logic        wr_en;
   logic [AW-1:0] wr_addr;
   entry_type   wr_data;

   entry_type   mem [STREAM_SLOTS];
   entry_type   rd_data_ff;
   logic [AW-1:0] rd_addr;

   // output register
   logic        ov_ff;
   logic [1:0]  okind_ff;
   logic [7:0]  odata_ff;
   logic [16:0] ocs_ff;
   logic [7:0]  otype_ff;
   logic [23:0] olen_ff;
   logic [30:0] ots_ff;
   logic [31:0] oid_ff;
   logic        olast_ff;
   logic [2:0]  oerr_ff;

   logic        emit, emit_err;
   logic [1:0]  ekind;
   logic [2:0]  ecode;
   logic        elast;
   logic [7:0]  edata;
   logic        accept;
   logic        out_free;

   assign out_free  = !ov_ff || !rsp_stall;
   assign req_stall = clr_ff || lookup_ff || !out_free;
   assign accept    = req_valid && !req_stall;
   assign rd_addr   = cur_in[AW-1:0];

   // table memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // parse datapath
   always_comb begin
      entry_type e;
      logic [23:0] d;
      logic [23:0] rem;
      logic [23:0] cs;
      logic        fresh;
      logic [3:0]  ni;
      logic        do_fin;
      logic        to_ext;
      logic [23:0] nrecv;
      phase_in  = phase_ff;
      fmt_in    = fmt_ff;
      cur_in    = cur_ff;
      idx_in    = idx_ff;
      shift_in  = shift_ff;
      left_in   = left_ff;
      lookup_in = 1'b0;
      ent_in    = ent_ff;
      emit      = 1'b0;
      emit_err  = 1'b0;
      ekind     = KIND_PAYLOAD;
      ecode     = ERR_NONE;
      elast     = 1'b0;
      edata     = 8'd0;
      wr_en     = 1'b0;
      wr_addr   = cur_ff[AW-1:0];
      e         = ent_ff;
      d         = 24'd0;
      rem       = 24'd0;
      fresh     = 1'b0;
      ni        = 4'd0;
      do_fin    = 1'b0;
      to_ext    = 1'b0;
      nrecv     = 24'd0;
      cs        = (chunk_size_ff == 24'd0) ? 24'd1 : chunk_size_ff;
      if (clr_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff[AW-1:0];
         e       = '0;
      end else if (lookup_ff) begin
         // header start on freshly read entry
         e = rd_data_ff;
         if (cur_ff >= 17'(STREAM_SLOTS)) begin
            emit_err = 1'b1; ecode = ERR_STREAM_ID;
         end else if (!e.seen && fmt_ff != 2'd0 &&
                      !(cur_ff == CID_CONTROL && fmt_ff == 2'd1)) begin
            emit_err = 1'b1; ecode = ERR_FRESH;
         end else if (e.partial && fmt_ff == 2'd0) begin
            emit_err = 1'b1; ecode = ERR_MID_MSG;
         end else begin
            fresh = !e.partial;
            if (fresh) begin
               e.partial  = 1'b1;
               e.received = 24'd0;
            end
            idx_in   = 4'd0;
            shift_in = 32'd0;
            if (fmt_ff == 2'd3) begin
               if (fresh && !e.extended) begin
                  e.timestamp = e.timestamp + {7'd0, e.delta};
               end
               if (e.extended) to_ext = 1'b1;
               else do_fin = 1'b1;
            end else begin
               phase_in = PH_MSGHDR;
            end
            wr_en = 1'b1;
         end
      end else if (accept) begin
         unique case (phase_ff)
            PH_BH0: begin
               fmt_in = req_in_byte[7:6];
               if (req_in_byte[5:0] == 6'd0) begin
                  cur_in = 17'd64; phase_in = PH_BH_TWO;
               end else if (req_in_byte[5:0] == 6'd1) begin
                  cur_in = 17'd64; phase_in = PH_BH_THREE_A;
               end else begin
                  cur_in = {11'd0, req_in_byte[5:0]}; lookup_in = 1'b1;
               end
            end
            PH_BH_TWO: begin
               cur_in = 17'd64 + {9'd0, req_in_byte}; lookup_in = 1'b1;
            end
            PH_BH_THREE_A: begin
               cur_in = 17'd64 + {9'd0, req_in_byte}; phase_in = PH_BH_THREE_B;
            end
            PH_BH_THREE_B: begin
               cur_in = cur_ff + {1'b0, req_in_byte, 8'd0}; lookup_in = 1'b1;
            end
            PH_MSGHDR: begin
               wr_en = 1'b1;
               if (idx_ff < 4'd3) begin
                  shift_in = {shift_ff[23:0], req_in_byte};
                  if (idx_ff == 4'd2) begin
                     d = shift_in[23:0];
                     e.delta    = d;
                     e.extended = (d == EXT_MARK);
                     if (d != EXT_MARK) begin
                        if (fmt_ff == 2'd0) e.timestamp = {7'd0, d};
                        else e.timestamp = e.timestamp + {7'd0, d};
                     end
                     shift_in = 32'd0;
                  end
               end else if (idx_ff < 4'd6) begin
                  shift_in = {shift_ff[23:0], req_in_byte};
                  if (idx_ff == 4'd5) begin
                     shift_in = 32'd0;
                     if (e.received != 24'd0 &&
                         e.received != {shift_ff[15:0], req_in_byte}) begin
                        emit_err = 1'b1; ecode = ERR_LENGTH; wr_en = 1'b0;
                     end
                     e.length = {shift_ff[15:0], req_in_byte};
                  end
               end else if (idx_ff == 4'd6) begin
                  e.mtype = req_in_byte;
               end else if (idx_ff == 4'd7) begin
                  e.msg_id = {24'd0, req_in_byte};
               end else if (idx_ff <= 4'd10) begin
                  e.msg_id = e.msg_id | ({24'd0, req_in_byte} << (5'd8 * 5'(idx_ff - 4'd7)));
               end
               ni     = idx_ff + 4'd1;
               idx_in = ni;
               if (!emit_err && ni >= mh_len(fmt_ff)) begin
                  if (e.extended) to_ext = 1'b1;
                  else do_fin = 1'b1;
               end
            end
            PH_EXT: begin
               shift_in = {shift_ff[23:0], req_in_byte};
               idx_in   = idx_ff + 4'd1;
               if (idx_in >= 4'd4) begin
                  if (!(e.received != 24'd0 && e.timestamp != 31'd0 &&
                        {1'b0, e.timestamp} != shift_in)) begin
                     e.timestamp = shift_in[30:0];
                  end
                  shift_in = 32'd0;
                  do_fin   = 1'b1;
                  wr_en    = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               nrecv      = e.received + 24'd1;
               e.received = nrecv;
               left_in    = left_ff - 24'd1;
               elast      = (nrecv >= e.length);
               if (elast) begin
                  e.partial = 1'b0; phase_in = PH_BH0;
               end else if (left_in == 24'd0) begin
                  phase_in = PH_BH0;
               end
               emit  = 1'b1;
               ekind = KIND_PAYLOAD;
               edata = req_in_byte;
               wr_en = 1'b1;
            end
            default: begin
            end
         endcase
      end
      if (to_ext) begin
         phase_in = PH_EXT; idx_in = 4'd0; shift_in = 32'd0;
      end
      if (do_fin) begin
         e.seen = 1'b1;
         if (e.length == 24'd0) begin
            e.partial = 1'b0;
            phase_in  = PH_BH0;
            emit      = 1'b1;
            ekind     = KIND_EMPTY;
         end else begin
            rem      = e.length - e.received;
            left_in  = (rem < cs) ? rem : cs;
            phase_in = PH_PAYLOAD;
         end
      end
      if (emit_err) begin
         phase_in = PH_ERROR;
         wr_en    = 1'b0;
      end
      ent_in  = e;
      wr_data = e;
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_size_ff <= CHUNK_RESET;
         phase_ff      <= PH_BH0;
         fmt_ff        <= 2'd0;
         cur_ff        <= 17'd0;
         idx_ff        <= 4'd0;
         shift_ff      <= 32'd0;
         left_ff       <= 24'd0;
         lookup_ff     <= 1'b0;
         clr_ff        <= 1'b1;
         clr_cnt_ff    <= '0;
         ov_ff         <= 1'b0;
      end else begin
         if (csr_write) chunk_size_ff <= csr_wdata;
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == (AW+1)'(STREAM_SLOTS - 1)) clr_ff <= 1'b0;
         end
         phase_ff  <= phase_in;
         fmt_ff    <= fmt_in;
         cur_ff    <= cur_in;
         idx_ff    <= idx_in;
         shift_ff  <= shift_in;
         left_ff   <= left_in;
         lookup_ff <= lookup_in;
         if (emit || emit_err) ov_ff <= 1'b1;
         else if (!rsp_stall) ov_ff <= 1'b0;
      end
   end

   // working entry and result payload
   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      if (emit_err) begin
         okind_ff <= KIND_ERROR; odata_ff <= 8'd0; ocs_ff <= cur_ff;
         otype_ff <= 8'd0; olen_ff <= 24'd0; ots_ff <= 31'd0;
         oid_ff <= 32'd0; olast_ff <= 1'b0; oerr_ff <= ecode;
      end else if (emit) begin
         okind_ff <= ekind; odata_ff <= edata; ocs_ff <= cur_ff;
         otype_ff <= ent_in.mtype; olen_ff <= ent_in.length;
         ots_ff <= ent_in.timestamp; oid_ff <= ent_in.msg_id;
         olast_ff <= elast; oerr_ff <= ERR_NONE;
      end
   end

   assign rsp_valid         = ov_ff;
   assign rsp_kind          = okind_ff;
   assign rsp_data_byte     = odata_ff;
   assign rsp_chunk_stream  = ocs_ff;
   assign rsp_msg_type      = otype_ff;
   assign rsp_msg_length    = olen_ff;
   assign rsp_msg_timestamp = ots_ff;
   assign rsp_msg_stream_id = oid_ff;
   assign rsp_last          = olast_ff;
   assign rsp_error_code    = oerr_ff;

endmodule

// File: sv/rcd_checker.sv
// rcd_checker: port level checks for rtmp_chunk_deframer
// depends on rcd_pkg; bound to the top level below
module rcd_checker
   import rcd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_data_byte,
   input logic        rsp_last,
   input logic [2:0]  rsp_error_code
);
   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_byte) && $stable(rsp_kind))
      else $error("stalled result changed");

   // a stalled result holds off the input
   a_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while result stalled");

   // error results carry a code, others none
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == KIND_ERROR) == (rsp_error_code != ERR_NONE)))
      else $error("error code mismatch");

   // last only on payload
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_kind == KIND_PAYLOAD)
      else $error("last on non payload");

   // nothing follows an error
   a_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_kind == KIND_ERROR |=> !rsp_valid)
      else $error("result after error");
endmodule

bind rtmp_chunk_deframer rcd_checker u_rcd_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
   .rsp_data_byte(rsp_data_byte), .rsp_last(rsp_last), .rsp_error_code(rsp_error_code)
);
